// File: hdl/sha256_pkg.sv
`default_nettype none

package sha256_pkg;

  localparam int WORD_W      = 32;
  localparam int BLOCK_BITS  = 512;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 64;
  localparam int OUT_TDATA_W = 40;

  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [LEN_W-1:0] BYTE_BITS = 64'd8;

  // H_INIT[0] is h0
  localparam logic [7:0][31:0] H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic       shift_en;
    byte_sel_t  byte_sel;
    logic [2:0] len_sel;
    logic       count_byte;
    logic       load_work;
    logic       round_en;
    logic [5:0] round_idx;
    logic       add_back;
    logic       out_load;
    logic [2:0] out_sel;
    logic       restart;
  } dp_cmd_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: hdl/sha256_ctrl.sv
`default_nettype none

module sha256_ctrl
  import sha256_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_func,
  output logic      in_ready,
  input  wire logic out_ready,
  output logic      out_valid,
  output dp_cmd_t   cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [5:0] round_r, round_nxt;
  logic [2:0] word_r, word_nxt;
  logic       fin_r, fin_nxt;
  logic       spill_r, spill_nxt;
  logic       final_r, final_nxt;
  logic       ovalid_r, ovalid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    round_nxt  = round_r;
    word_nxt   = word_r;
    fin_nxt    = fin_r;
    spill_nxt  = spill_r;
    final_nxt  = final_r;
    ovalid_nxt = ovalid_r;

    cmd.len_sel   = fill_r[2:0];
    cmd.round_idx = round_r;
    cmd.out_sel   = word_r;

    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.shift_en = 1'b1;
          fill_nxt     = fill_r + 6'd1;
          if (!in_func) begin
            cmd.byte_sel   = SEL_DATA;
            cmd.count_byte = 1'b1;
          end else begin
            cmd.byte_sel = SEL_PAD;
            fin_nxt      = 1'b1;
            // marker lands in the length field: the length goes in one extra block
            spill_nxt    = (fill_r >= LEN_POS) && (fill_r != LAST_POS);
            if (fill_r != LAST_POS) state_nxt = ST_PAD;
          end
          if (fill_r == LAST_POS) begin
            cmd.load_work = 1'b1;
            round_nxt     = '0;
            state_nxt     = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        cmd.shift_en = 1'b1;
        fill_nxt     = fill_r + 6'd1;
        if (!spill_r && (fill_r >= LEN_POS)) cmd.byte_sel = SEL_LEN;
        else                                 cmd.byte_sel = SEL_ZERO;
        if (fill_r == LAST_POS) begin
          cmd.load_work = 1'b1;
          round_nxt     = '0;
          final_nxt     = !spill_r;
          spill_nxt     = 1'b0;
          state_nxt     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        round_nxt    = round_r + 6'd1;
        if (round_r == LAST_ROUND) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add_back = 1'b1;
        if (final_r) begin
          word_nxt  = '0;
          state_nxt = ST_OUT;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!ovalid_r || out_ready) begin
          cmd.out_load = 1'b1;
          ovalid_nxt   = 1'b1;
          word_nxt     = word_r + 3'd1;
          if (word_r == LAST_WORD) begin
            cmd.restart = 1'b1;
            fin_nxt     = 1'b0;
            final_nxt   = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      round_r  <= '0;
      word_r   <= '0;
      fin_r    <= 1'b0;
      spill_r  <= 1'b0;
      final_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      round_r  <= round_nxt;
      word_r   <= word_nxt;
      fin_r    <= fin_nxt;
      spill_r  <= spill_nxt;
      final_r  <= final_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sha256_dp.sv
`default_nettype none

module sha256_dp
  import sha256_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  input  wire logic [BYTE_W-1:0] data_byte,
  output logic [WORD_W-1:0]      out_word,
  output logic [2:0]             out_idx
);

  // message block as a byte shift line; word 0 sits in the top bits
  logic [BLOCK_BITS-1:0] msg_r;
  logic [WORD_W-1:0]     v_r [8];
  logic [WORD_W-1:0]     chain_r [8];
  logic [LEN_W-1:0]      len_r;
  logic [WORD_W-1:0]     out_word_r;
  logic [2:0]            out_idx_r;

  logic [BYTE_W-1:0] byte_in;
  logic [LEN_W-1:0]  len_shift;
  logic [WORD_W-1:0] w0, w1, w9, w14, w_new;
  logic [WORD_W-1:0] t1, t2, ch, maj;

  assign len_shift = len_r << {cmd.len_sel, 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      SEL_DATA: byte_in = data_byte;
      SEL_PAD:  byte_in = PAD_BYTE;
      SEL_LEN:  byte_in = len_shift[LEN_W-1 -: BYTE_W];
      default:  byte_in = '0;
    endcase
  end

  assign w0    = msg_r[BLOCK_BITS-1 -: WORD_W];
  assign w1    = msg_r[BLOCK_BITS-1-WORD_W -: WORD_W];
  assign w9    = msg_r[BLOCK_BITS-1-9*WORD_W -: WORD_W];
  assign w14   = msg_r[BLOCK_BITS-1-14*WORD_W -: WORD_W];
  assign w_new = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);

  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + big_sigma1(v_r[4]) + ch + round_const(cmd.round_idx) + w0;
  assign t2  = big_sigma0(v_r[0]) + maj;

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      msg_r <= {msg_r[BLOCK_BITS-BYTE_W-1:0], byte_in};
    end else if (cmd.round_en) begin
      // retire the used word, append the next schedule word
      msg_r <= {msg_r[BLOCK_BITS-WORD_W-1:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      for (int i = 0; i < 8; i++) v_r[i] <= chain_r[i];
    end else if (cmd.round_en) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= H_INIT[i];
      len_r <= '0;
    end else begin
      if (cmd.add_back) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + v_r[i];
      end
      if (cmd.count_byte) len_r <= len_r + BYTE_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r <= chain_r[cmd.out_sel];
      out_idx_r  <= cmd.out_sel;
    end
  end

  assign out_word = out_word_r;
  assign out_idx  = out_idx_r;

endmodule

`default_nettype wire

// File: hdl/sha256_stream_hasher.sv
// Channel | Dir | Ports                         | Item
// in_     | in  | tvalid tready tdata[7:0] tuser | one message byte, or finish
// out_    | out | tvalid tready tdata[39:0] tlast | one digest word, h0 first
//
// Bytes are absorbed one per cycle while idle; the 64th byte of a block
// starts 64 rounds on one shared round unit, then the add-back, and no input
// is taken meanwhile. Finish pads with zeros and the length and compresses,
// twice if 56 to 63 bytes are held, then one word per cycle unless stalled.
// Synchronous reset loads the initial hash values; no clearing pass.
// A stalled word holds in the output register; the next input byte is taken
// as soon as the last word is loaded.
`default_nettype none

module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]             in_tuser,   // [0] func
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic                        out_tlast   // last_word
);

  dp_cmd_t           dp_cmd;
  logic [WORD_W-1:0] out_word;
  logic [2:0]        out_idx;

  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_func   (in_tuser[0]),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .cmd       (dp_cmd)
  );

  sha256_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (dp_cmd),
    .data_byte (in_tdata),
    .out_word  (out_word),
    .out_idx   (out_idx)
  );

  assign out_tdata = {5'b00000, out_idx, out_word};
  assign out_tlast = (out_idx == LAST_WORD);

`ifndef SYNTHESIS
  a_no_accept_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.round_en |-> !in_tready)
    else $error("input ready during compression");

  a_restart_shows_last: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.restart |=> out_tvalid && out_tlast)
    else $error("final digest word not presented after restart");

  a_shift_when_accepting: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> dp_cmd.shift_en)
    else $error("accepted item not shifted into block");
`endif

endmodule

`default_nettype wire
